// ----- hw/rtl/lcem_pkg.sv -----
// Package for the lookahead colour edge marker: constants, types and helpers.
package lcem_pkg;

   localparam int LOOKAHEAD   = 6;
   localparam int NUM_CH      = 3;
   localparam int CH_W        = 8;
   localparam int CNT_W       = $clog2(LOOKAHEAD + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int PIX_W       = NUM_CH * CH_W;

   localparam logic [CH_W-1:0] THRESHOLD_RESET = 8'd86;
   localparam logic [CH_W-1:0] FILL_RESET      = 8'd1;

   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FILL      = 1'd1;

   // index 0 is channel a
   typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_type;

   typedef struct packed {
      logic      last;
      pixel_type pixel;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      logic      full;
      entry_type entry;
   } queue_status_type;

   function automatic logic far_apart(input logic [CH_W-1:0] a,
                                      input logic [CH_W-1:0] b,
                                      input logic [CH_W-1:0] thr);
      logic [CH_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d > thr;
   endfunction

endpackage

// ----- hw/rtl/lcem_front.sv -----
// Front end: pixel window, edge judgement, row-end flush and config registers.
module lcem_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  lcem_pkg::pixel_type                req_pixel,
   input  logic                               req_last,
   input  logic                               csr_we,
   input  logic [lcem_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [lcem_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  lcem_pkg::queue_status_type         q_status,
   output lcem_pkg::push_type                 q_push
);
   import lcem_pkg::*;

   pixel_type [LOOKAHEAD-1:0] win_ff, win_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      flush_ff, flush_in;
   logic [CH_W-1:0]           thr_ff, fill_ff;

   pixel_type [LOOKAHEAD-1:0] fol;
   logic [NUM_CH-1:0]         edge_ch;
   pixel_type                 judged;
   logic                      accept;
   logic                      window_full;

   assign req_tready  = !flush_ff && !q_status.full;
   assign accept      = req_tvalid && req_tready;
   assign window_full = (count_ff == CNT_W'(LOOKAHEAD));

   // followers of the oldest held pixel, incoming one last
   always_comb begin
      for (int k = 0; k < LOOKAHEAD - 1; k++) begin
         fol[k] = win_ff[k+1];
      end
      fol[LOOKAHEAD-1] = req_pixel;
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         edge_ch[c] = 1'b1;
         for (int k = 0; k < LOOKAHEAD; k++) begin
            if (!far_apart(fol[k][c], win_ff[0][c], thr_ff)) begin
               edge_ch[c] = 1'b0;
            end
         end
      end
      for (int c = 0; c < NUM_CH; c++) begin
         judged[c] = (|edge_ch) ? fol[0][c] : fill_ff;
      end
   end

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      flush_in = flush_ff;
      q_push   = '0;
      if (flush_ff) begin
         if (!q_status.full) begin
            q_push.valid       = 1'b1;
            q_push.entry.pixel = win_ff[0];
            q_push.entry.last  = (count_ff == CNT_W'(1));
            for (int i = 0; i < LOOKAHEAD - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               flush_in = 1'b0;
            end
         end
      end else if (accept) begin
         if (window_full) begin
            q_push.valid       = 1'b1;
            q_push.entry.pixel = judged;
            q_push.entry.last  = 1'b0;
            for (int i = 0; i < LOOKAHEAD - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[LOOKAHEAD-1] = req_pixel;
         end else begin
            for (int i = 0; i < LOOKAHEAD; i++) begin
               if (count_ff == CNT_W'(i)) begin
                  win_in[i] = req_pixel;
               end
            end
            count_in = count_ff + CNT_W'(1);
         end
         flush_in = req_last;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         count_ff <= '0;
         flush_ff <= 1'b0;
         thr_ff   <= THRESHOLD_RESET;
         fill_ff  <= FILL_RESET;
      end else begin
         count_ff <= count_in;
         flush_ff <= flush_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_THRESHOLD: thr_ff  <= csr_wdata;
               CSR_FILL:      fill_ff <= csr_wdata;
            endcase
         end
      end
   end

endmodule

// ----- hw/rtl/lcem_queue.sv -----
// Short result queue between front and back ends.
module lcem_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  lcem_pkg::push_type         q_push,
   input  logic                       q_pop,
   output lcem_pkg::queue_status_type q_status
);
   import lcem_pkg::*;

   entry_type [QUEUE_DEPTH-1:0] mem_ff;
   logic [QPTR_W-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]           cnt_ff, cnt_in;
   logic                        do_pop;

   assign q_status.valid = (cnt_ff != '0);
   assign q_status.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.entry = mem_ff[rd_ptr_ff];
   assign do_pop         = q_pop && q_status.valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (q_push.valid && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!q_push.valid && do_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         mem_ff[wr_ptr_ff] <= q_push.entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (q_push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

// ----- hw/rtl/lcem_back.sv -----
// Back end: output register driving the result stream.
module lcem_back (
   input  logic                       clock,
   input  logic                       reset,
   input  lcem_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output lcem_pkg::entry_type        rsp_entry
);
   import lcem_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff;

   assign q_pop      = q_status.valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_entry  = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         entry_ff <= q_status.entry;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- hw/rtl/lookahead_color_edge_marker_top.sv -----
// Top level of the lookahead colour edge marker.
// Throughput: one pixel per cycle while the queue is not full; a row end adds a
//   flush of the held pixels (up to six) in which req_tready is low while the window drains.
// Result path: a result enters the queue at the transfer that completes its six
//   followers and reaches rsp_tdata through the queue, then the output register.
// Reset: synchronous, active high; empties window, queue and output register and
//   loads threshold 86 and fill value 1.
module lookahead_color_edge_marker_top (
   input  logic                                clock,
   input  logic                                reset,
   // input pixel stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // chan_a, chan_b, chan_c
   input  logic                                req_tlast,  // row_end
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,  // chan_a, chan_b, chan_c
   output logic                                rsp_tlast,  // row_end
   // register writes: 0 threshold, 1 fill value
   input  logic                                csr_we,
   input  logic [lcem_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [lcem_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lcem_pkg::*;

   pixel_type        req_pixel;
   push_type         q_push;
   queue_status_type q_status;
   logic             q_pop;
   entry_type        rsp_entry;

   // tdata packs channel a in the low byte, matching pixel_type's index order
   assign req_pixel = pixel_type'(req_tdata);

   // front: window of held pixels, judging and row-end flush
   lcem_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_pixel  (req_pixel),
      .req_last   (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push)
   );

   // queue decouples judging from a stalled consumer
   lcem_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status)
   );

   // back: output register, one result transfer per cycle while rsp_tready is high
   lcem_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_entry  (rsp_entry)
   );

   assign rsp_tdata = rsp_entry.pixel;
   assign rsp_tlast = rsp_entry.last;

endmodule

// ----- tb/lookahead_color_edge_marker_top_tb.sv -----
// Self-checking testbench for the lookahead colour edge marker, with its scoreboard and drivers.
module lookahead_color_edge_marker_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lcem_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int          SETTLE      = 10;      // two-stage output plus a full flush
   localparam int          PHASE_ITEMS = 50;

   // Predicts the processed pixel stream and holds what is still owed by the block.
   class pixel_scoreboard;
      logic [CH_W-1:0] threshold  = THRESHOLD_RESET;
      logic [CH_W-1:0] fill_value = FILL_RESET;
      pixel_type       held[LOOKAHEAD];
      int              held_count = 0;
      entry_type       expected_pixels[$];
      int              failures   = 0;

      function void set_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
         case (addr)
            CSR_THRESHOLD: threshold = value;
            CSR_FILL:      fill_value = value;
            default: ;
         endcase
      endfunction

      // One accepted pixel: judge the oldest if it now has all its followers,
      // and flush the window at a row end.
      function void take_pixel(pixel_type px, logic row_end);
         pixel_type       win[LOOKAHEAD+1];
         pixel_type       res;
         entry_type       e;
         logic [CH_W-1:0] delta;
         int              n, first, i, k, c;
         bit              edge_hit, all_far;
         for (i = 0; i < held_count; i++)
            win[i] = held[i];
         win[held_count] = px;
         n = held_count + 1;
         first = 0;
         if (n == LOOKAHEAD + 1) begin
            edge_hit = 1'b0;
            for (c = 0; c < NUM_CH; c++) begin
               all_far = 1'b1;
               for (k = 1; k <= LOOKAHEAD; k++) begin
                  delta = (win[k][c] > win[0][c]) ? win[k][c] - win[0][c]
                                                  : win[0][c] - win[k][c];
                  if (!(delta > threshold))
                     all_far = 1'b0;
               end
               if (all_far)
                  edge_hit = 1'b1;
            end
            res = edge_hit ? win[1] : {NUM_CH{fill_value}};
            e.last  = 1'b0;
            e.pixel = res;
            expected_pixels.push_back(e);
            first = 1;
         end
         if (row_end) begin
            for (i = first; i < n; i++) begin
               e.last  = (i == n - 1);
               e.pixel = win[i];
               expected_pixels.push_back(e);
            end
            held_count = 0;
         end else begin
            held_count = n - first;
            for (i = 0; i < held_count; i++)
               held[i] = win[first + i];
         end
      endfunction

      function void check_pixel(pixel_type got, logic got_last);
         entry_type want;
         int        c;
         if (expected_pixels.size() == 0) begin
            $error("result with nothing expected: tdata %h tlast %b", got, got_last);
            failures++;
            return;
         end
         want = expected_pixels.pop_front();
         for (c = 0; c < NUM_CH; c++) begin
            if (got[c] !== want.pixel[c]) begin
               $error("chan_%c_out: expected %0d, got %0d", 8'h61 + c, want.pixel[c], got[c]);
               failures++;
            end
         end
         if (got_last !== want.last) begin
            $error("row_end_out: expected %0d, got %0d", want.last, got_last);
            failures++;
         end
      endfunction
   endclass

   // Clock, reset and every block input start at known values.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;     // chan_a, chan_b, chan_c
   logic                  req_tlast  = 1'b0;   // row_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;           // chan_a, chan_b, chan_c
   logic                  rsp_tlast;           // row_end
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   pixel_scoreboard board = new;
   bit              quiet = 1'b0;   // set: neither side idles
   int unsigned     cycle_count = 0;

   always #5 clock = ~clock;

   lookahead_color_edge_marker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Watchdog: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Receiver: ready most of the time, with occasional stall bursts
   // unless the run is in a quiet stretch. One ready update per edge.
   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Result transfers are checked on the edge at which they happen; the
   // values seen here are those from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         board.check_pixel(rsp_tdata, rsp_tlast);
   end

   function automatic pixel_type rgb(input int a, input int b, input int c);
      pixel_type px;
      px[0] = CH_W'(a);
      px[1] = CH_W'(b);
      px[2] = CH_W'(c);
      return px;
   endfunction

   // Offer one pixel and hold it until the transfer; the scoreboard learns of
   // it at the edge where it is taken. Valid stays high into the next pixel unless an idle gap is drawn.
   task automatic send_pixel(input pixel_type px, input logic row_end);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tlast  <= row_end;
      do
         @(posedge clock);
      while (!req_tready);
      board.take_pixel(px, row_end);
   endtask

   task automatic send_run(input pixel_type px, input int count, input logic close_row);
      int i;
      for (i = 0; i < count; i++)
         send_pixel(px, close_row && i == count - 1);
   endtask

   // A random row: either flat runs of colour that jump between dark and
   // bright levels (where edges live), or plain noise.
   task automatic send_row(input int len);
      pixel_type level, px;
      bit        stepped;
      int        i, c;
      stepped = $urandom_range(0, 9) < 7;
      for (c = 0; c < NUM_CH; c++)
         level[c] = $urandom_range(0, 1) ? CH_W'($urandom_range(215, 255))
                                         : CH_W'($urandom_range(0, 40));
      for (i = 0; i < len; i++) begin
         if (stepped) begin
            if ($urandom_range(0, 5) == 0)
               for (c = 0; c < NUM_CH; c++)
                  level[c] = $urandom_range(0, 1) ? CH_W'($urandom_range(215, 255))
                                                  : CH_W'($urandom_range(0, 40));
            px = level;
         end else begin
            for (c = 0; c < NUM_CH; c++)
               px[c] = CH_W'($urandom_range(0, 255));
         end
         send_pixel(px, i == len - 1);
      end
   endtask

   // Let everything owed come out, then allow the window flush and output
   // stages to settle before touching the registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Both registers, on back-to-back edges.
   task automatic configure(input logic [CSR_DATA_W-1:0] thr,
                            input logic [CSR_DATA_W-1:0] fill);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_THRESHOLD;
      csr_wdata <= thr;
      @(posedge clock);
      board.set_reg(CSR_THRESHOLD, thr);
      csr_addr  <= CSR_FILL;
      csr_wdata <= fill;
      @(posedge clock);
      board.set_reg(CSR_FILL, fill);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int phase_no, sent, len, pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings (threshold 86, fill 1).
      // Single-pixel row: flushed straight out, unchanged.
      send_pixel(rgb(255, 255, 255), 1'b1);
      // Full row: channel a differs by 87 from every follower, so the first
      // pixel takes its neighbour's colour; b sits exactly on the threshold.
      send_pixel(rgb(0, 100, 40), 1'b0);
      send_run(rgb(87, 186, 200), 6, 1'b1);
      // Short row: never judged, flushed unchanged.
      send_run(rgb(0, 255, 0), 2, 1'b0);
      send_pixel(rgb(255, 0, 255), 1'b1);
      // Every channel exactly at the threshold: not an edge, becomes fill.
      send_pixel(rgb(100, 100, 100), 1'b0);
      send_run(rgb(186, 14, 186), 6, 1'b1);
      drain();

      for (phase_no = 0; phase_no < 6; phase_no++) begin
         case (phase_no)
            0: begin
               // Threshold at maximum: even 0 against 255 is not far enough.
               configure(8'd255, 8'd0);
               send_pixel(rgb(0, 255, 0), 1'b0);
               send_run(rgb(255, 0, 255), 6, 1'b1);
            end
            1: configure(8'd0, 8'd255);
            2: configure(CSR_DATA_W'($urandom_range(0, 255)),
                         CSR_DATA_W'($urandom_range(0, 255)));
            3: begin
               quiet = 1'b1;   // a stretch with no idling on either side
               configure(CSR_DATA_W'($urandom_range(100, 180)),
                         CSR_DATA_W'($urandom_range(0, 255)));
            end
            4: begin
               quiet = 1'b0;
               configure(CSR_DATA_W'($urandom_range(0, 255)),
                         CSR_DATA_W'($urandom_range(0, 255)));
            end
            default: begin
               quiet = 1'b1;   // closing part runs at full rate
               configure(CSR_DATA_W'($urandom_range(40, 160)),
                         CSR_DATA_W'($urandom_range(0, 255)));
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            // Mostly short rows, a fair share of exactly one judged pixel,
            // now and then a long one.
            pick = $urandom_range(0, 9);
            if (pick < 2)
               len = LOOKAHEAD + 1;
            else if (pick == 9)
               len = $urandom_range(25, 50);
            else
               len = $urandom_range(1, 16);
            send_row(len);
            sent += len;
         end
         drain();
      end

      if (board.failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
